/* rtl/mwdl_pkg.sv */
// shared constants and types for the motion wake display and led controller
`default_nettype none

package mwdl_pkg;

	localparam int BREATH_STEPS_DEF = 256;

	// shared divider sizes
	localparam int DIV_W = 32;
	localparam int CNT_W = 6;
	localparam int SIN_QB = 17;

	// shared multiplier sizes
	localparam int MUL_W = 17;
	localparam int PROD_W = 2 * MUL_W;

	// configuration port
	localparam int CFG_W = 17;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_MOTION_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAKE_DURATION_MS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STALE_MS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BREATH_PERIOD_MS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BREATH_FLOOR = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WARN_PPM = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CRIT_PPM = 3'd6;

	localparam logic [16:0] MOTION_THRESHOLD_RST = 17'd358;
	localparam logic [15:0] WAKE_DURATION_MS_RST = 16'd7000;
	localparam logic [15:0] STALE_MS_RST = 16'd30000;
	localparam logic [15:0] BREATH_PERIOD_MS_RST = 16'd5000;
	localparam logic [7:0] BREATH_FLOOR_RST = 8'd13;
	localparam logic [15:0] WARN_PPM_RST = 16'd1000;
	localparam logic [15:0] CRIT_PPM_RST = 16'd1500;

	// telemetry kinds
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_CO2 = 2'd1;
	localparam logic [1:0] KIND_OTHER = 2'd2;

	// band colors
	localparam logic [7:0] LVL_FULL = 8'd255;
	localparam logic [7:0] LVL_AMBER_G = 8'd170;
	localparam logic [7:0] LVL_OFF = 8'd0;

	// stream widths
	localparam int S_TDATA_W = 104;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 32;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] count;
	} div_ctl_t;

endpackage

`default_nettype wire

/* rtl/mwdl_div.sv */
// restoring divider, one quotient bit per cycle, shared by the phase and table steps
`default_nettype none

module mwdl_div #(
	parameter int DVW = 23
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire mwdl_pkg::div_ctl_t        ctl,
	input  wire logic [DVW-1:0]            rem_init,
	input  wire logic [mwdl_pkg::DIV_W-1:0] quo_init,
	input  wire logic [DVW-1:0]            divisor,
	output logic                           done,
	output logic [DVW-1:0]                 rem,
	output logic [mwdl_pkg::DIV_W-1:0]     quo
);
	import mwdl_pkg::*;

	logic [DVW-1:0]   rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVW-1:0]   div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;

	logic [DVW:0] trial;
	logic [DVW:0] diff;
	logic         ge;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff = trial - {1'b0, div_q};
	assign ge = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q <= ctl.count;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= rem_init;
			quo_q <= quo_init;
			div_q <= divisor;
		end else if (busy_q && (cnt_q != '0)) begin
			rem_q <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign done = busy_q && (cnt_q == '0);
	assign rem = rem_q;
	assign quo = quo_q;

endmodule

`default_nettype wire

/* rtl/motion_wake_display_led_controller_top.sv */
// top level of the motion wake display and co2 led controller
//
// one input transfer on s_* is one tick; it gives exactly one output transfer on m_*.
// configuration registers are written on cfg_*, which is always ready; write only
// while no tick is in flight.
// a tick updates tap, motion wake, auto-off and telemetry state in its first cycle.
// when the led is dark (display off, stale data or no co2 yet) the tick goes from the
// update state straight to the output state.
// when lit, a shared restoring divider (one bit per cycle) and a shared 17x17
// multiplier work out the breathing phase, the table index and the sine term of
// the table entry, and the multiplier scales the floor and the red and green
// levels; with a zero breathing period the phase and index steps are skipped.
// s_tready is high only while no tick is being worked on; one tick at a time, so a
// new tick is taken only once the last one has left the output state.
// the result sits in an output register, so the next tick is taken while a
// finished result still waits for m_tready.
// a stalled receiver holds m_tdata; the last tick cannot finish until it drains.
// reset turns the display on, clears motion mode, telemetry and the previous
// sample, and loads the default register values.
`default_nettype none

module motion_wake_display_led_controller_top #(
	parameter int BREATH_STEPS = mwdl_pkg::BREATH_STEPS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [mwdl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mwdl_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// now_ms, tap, accel_x, accel_y, accel_z, co2_ppm, zero fill
	input  wire logic [mwdl_pkg::S_TDATA_W-1:0] s_tdata,
	// accel_valid, sample_kind
	input  wire logic [mwdl_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// display_on, woke_by_motion, data_fresh, led_red, led_green, led_blue, zero fill
	output logic [mwdl_pkg::M_TDATA_W-1:0]      m_tdata
);
	import mwdl_pkg::*;

	localparam int LOGN = $clog2(BREATH_STEPS);
	localparam int NSQ5 = 5 * BREATH_STEPS * BREATH_STEPS;
	localparam int DEN_W = $clog2(NSQ5 + 1);
	localparam int DVW = (DEN_W > 16) ? DEN_W : 16;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_UPD   = 4'd1;
	localparam logic [3:0] ST_MODW  = 4'd2;
	localparam logic [3:0] ST_PHN   = 4'd3;
	localparam logic [3:0] ST_IDXGO = 4'd4;
	localparam logic [3:0] ST_IDXW  = 4'd5;
	localparam logic [3:0] ST_PMUL  = 4'd6;
	localparam logic [3:0] ST_SGO   = 4'd7;
	localparam logic [3:0] ST_SW    = 4'd8;
	localparam logic [3:0] ST_SSQ   = 4'd9;
	localparam logic [3:0] ST_FMUL  = 4'd10;
	localparam logic [3:0] ST_RMUL  = 4'd11;
	localparam logic [3:0] ST_GMUL  = 4'd12;
	localparam logic [3:0] ST_FIN   = 4'd13;

	// configuration
	logic [16:0] motion_threshold_q;
	logic [15:0] wake_duration_ms_q;
	logic [15:0] stale_ms_q;
	logic [15:0] breath_period_ms_q;
	logic [7:0]  breath_floor_q;
	logic [15:0] warn_ppm_q;
	logic [15:0] crit_ppm_q;

	// tick fields
	logic [31:0]        now_q;
	logic               tap_q;
	logic               accel_valid_q;
	logic signed [15:0] accel_x_q;
	logic signed [15:0] accel_y_q;
	logic signed [15:0] accel_z_q;
	logic [1:0]         kind_q;
	logic [15:0]        co2_in_q;

	// block state
	logic               screen_on_q;
	logic               motion_mode_q;
	logic [31:0]        wake_deadline_q;
	logic signed [15:0] prev_x_q;
	logic signed [15:0] prev_y_q;
	logic signed [15:0] prev_z_q;
	logic               have_data_q;
	logic [31:0]        last_data_time_q;
	logic               co2_present_q;
	logic [15:0]        co2_value_q;

	// sequencer and work registers
	logic [3:0]          state_q;
	logic                fresh_q;
	logic                lit_q;
	logic [7:0]          base_r_q;
	logic [7:0]          base_g_q;
	logic [15:0]         ph_q;
	logic [LOGN-1:0]     idx_q;
	logic [16:0]         f_q;
	logic [7:0]          red_q;
	logic [PROD_W-1:0]   mul_q;
	logic                m_valid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	// update step
	logic               scr_n;
	logic               mm_n;
	logic [31:0]        dl_n;
	logic               have_n;
	logic [31:0]        last_n;
	logic               co2p_n;
	logic [15:0]        co2v_n;
	logic               fresh_n;
	logic               lit_n;
	logic signed [16:0] dx;
	logic signed [16:0] dy;
	logic signed [16:0] dz;
	logic [15:0]        adx;
	logic [15:0]        ady;
	logic [15:0]        adz;
	logic [17:0]        dsum;
	logic               moved;
	logic [31:0]        dl_age;
	logic [31:0]        data_age;
	logic [7:0]         band_r;
	logic [7:0]         band_g;

	// shared units
	div_ctl_t           div_ctl;
	logic [DVW-1:0]     div_rem_init;
	logic [DIV_W-1:0]   div_quo_init;
	logic [DVW-1:0]     div_divisor;
	logic               div_done;
	logic [DVW-1:0]     div_rem;
	logic [DIV_W-1:0]   div_quo;
	logic               mul_en;
	logic [MUL_W-1:0]   mul_a;
	logic [MUL_W-1:0]   mul_b;
	logic [DVW-1:0]     p_w;
	logic [PROD_W-1:0]  w_sum;
	logic [16:0]        w_val;
	logic [PROD_W-1:0]  fr_sum;
	logic [16:0]        f_val;
	logic               out_free;

	assign cfg_ready = 1'b1;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motion_threshold_q <= MOTION_THRESHOLD_RST;
			wake_duration_ms_q <= WAKE_DURATION_MS_RST;
			stale_ms_q <= STALE_MS_RST;
			breath_period_ms_q <= BREATH_PERIOD_MS_RST;
			breath_floor_q <= BREATH_FLOOR_RST;
			warn_ppm_q <= WARN_PPM_RST;
			crit_ppm_q <= CRIT_PPM_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MOTION_THRESHOLD: motion_threshold_q <= cfg_data;
				REG_WAKE_DURATION_MS: wake_duration_ms_q <= cfg_data[15:0];
				REG_STALE_MS:         stale_ms_q <= cfg_data[15:0];
				REG_BREATH_PERIOD_MS: breath_period_ms_q <= cfg_data[15:0];
				REG_BREATH_FLOOR:     breath_floor_q <= cfg_data[7:0];
				REG_WARN_PPM:         warn_ppm_q <= cfg_data[15:0];
				REG_CRIT_PPM:         crit_ppm_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			now_q <= s_tdata[31:0];
			tap_q <= s_tdata[32];
			accel_x_q <= s_tdata[48:33];
			accel_y_q <= s_tdata[64:49];
			accel_z_q <= s_tdata[80:65];
			co2_in_q <= s_tdata[96:81];
			accel_valid_q <= s_tuser[0];
			kind_q <= s_tuser[2:1];
		end
	end

	// tap, motion check, auto-off, telemetry latch, freshness and band
	always_comb begin
		scr_n = screen_on_q;
		mm_n = motion_mode_q;
		dl_n = wake_deadline_q;
		if (tap_q) begin
			scr_n = !scr_n;
			mm_n = 1'b0;
		end
		dx = {accel_x_q[15], accel_x_q} - {prev_x_q[15], prev_x_q};
		dy = {accel_y_q[15], accel_y_q} - {prev_y_q[15], prev_y_q};
		dz = {accel_z_q[15], accel_z_q} - {prev_z_q[15], prev_z_q};
		adx = dx[16] ? 16'(-dx) : dx[15:0];
		ady = dy[16] ? 16'(-dy) : dy[15:0];
		adz = dz[16] ? 16'(-dz) : dz[15:0];
		dsum = 18'(adx) + 18'(ady) + 18'(adz);
		moved = (dsum > 18'(motion_threshold_q));
		if (accel_valid_q && moved) begin
			if (!scr_n) begin
				scr_n = 1'b1;
				mm_n = 1'b1;
				dl_n = now_q + 32'(wake_duration_ms_q);
			end else if (mm_n) begin
				dl_n = now_q + 32'(wake_duration_ms_q);
			end
		end
		dl_age = now_q - dl_n;
		if (mm_n && scr_n && !dl_age[31]) begin
			scr_n = 1'b0;
			mm_n = 1'b0;
		end
		co2p_n = co2_present_q;
		co2v_n = co2_value_q;
		if (kind_q == KIND_CO2) begin
			co2p_n = 1'b1;
			co2v_n = co2_in_q;
		end
		have_n = have_data_q;
		last_n = last_data_time_q;
		if ((kind_q == KIND_CO2) || (kind_q == KIND_OTHER)) begin
			have_n = 1'b1;
			last_n = now_q;
		end
		data_age = now_q - last_n;
		fresh_n = have_n && (data_age < 32'(stale_ms_q));
		lit_n = scr_n && fresh_n && co2p_n;
		priority if (co2v_n < warn_ppm_q) begin
			band_r = LVL_OFF;
			band_g = LVL_FULL;
		end else if (co2v_n <= crit_ppm_q) begin
			band_r = LVL_FULL;
			band_g = LVL_AMBER_G;
		end else begin
			band_r = LVL_FULL;
			band_g = LVL_OFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_on_q <= 1'b1;
			motion_mode_q <= 1'b0;
			wake_deadline_q <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_z_q <= '0;
			have_data_q <= 1'b0;
			last_data_time_q <= '0;
			co2_present_q <= 1'b0;
			co2_value_q <= '0;
		end else if (state_q == ST_UPD) begin
			screen_on_q <= scr_n;
			motion_mode_q <= mm_n;
			wake_deadline_q <= dl_n;
			if (accel_valid_q) begin
				prev_x_q <= accel_x_q;
				prev_y_q <= accel_y_q;
				prev_z_q <= accel_z_q;
			end
			have_data_q <= have_n;
			last_data_time_q <= last_n;
			co2_present_q <= co2p_n;
			co2_value_q <= co2v_n;
		end
	end

	// shared unit operands
	assign p_w = DVW'(mul_q);
	assign w_sum = mul_q + PROD_W'(32768);
	assign w_val = w_sum[32:16];
	assign fr_sum = mul_q + PROD_W'(128);
	assign f_val = 17'({breath_floor_q, 8'h00}) + fr_sum[24:8];

	always_comb begin
		div_ctl.start = 1'b0;
		div_ctl.count = '0;
		div_rem_init = '0;
		div_quo_init = '0;
		div_divisor = DVW'(breath_period_ms_q);
		mul_en = 1'b0;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_UPD: begin
				div_ctl.start = lit_n && (breath_period_ms_q != '0);
				div_ctl.count = CNT_W'(DIV_W);
				div_quo_init = now_q;
			end
			ST_PHN: begin
				mul_en = 1'b1;
				mul_a = MUL_W'(ph_q);
				mul_b = MUL_W'(BREATH_STEPS);
			end
			ST_IDXGO: begin
				div_ctl.start = 1'b1;
				div_ctl.count = CNT_W'(LOGN);
				div_rem_init = DVW'(mul_q >> LOGN);
				div_quo_init = {mul_q[LOGN-1:0], {(DIV_W-LOGN){1'b0}}};
			end
			ST_PMUL: begin
				mul_en = 1'b1;
				mul_a = MUL_W'(idx_q);
				mul_b = MUL_W'(BREATH_STEPS) - MUL_W'(idx_q);
			end
			ST_SGO: begin
				div_ctl.start = 1'b1;
				div_ctl.count = CNT_W'(SIN_QB);
				div_rem_init = p_w << 3;
				div_divisor = DVW'(NSQ5) - (p_w << 2);
			end
			ST_SSQ: begin
				mul_en = 1'b1;
				mul_a = div_quo[MUL_W-1:0];
				mul_b = div_quo[MUL_W-1:0];
			end
			ST_FMUL: begin
				mul_en = 1'b1;
				mul_a = MUL_W'(9'(256) - 9'(breath_floor_q));
				mul_b = w_val;
			end
			ST_RMUL: begin
				mul_en = 1'b1;
				mul_a = MUL_W'(base_r_q);
				mul_b = f_val;
			end
			ST_GMUL: begin
				mul_en = 1'b1;
				mul_a = MUL_W'(base_g_q);
				mul_b = f_q;
			end
			default: begin
			end
		endcase
	end

	mwdl_div #(
		.DVW(DVW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.rem_init (div_rem_init),
		.quo_init (div_quo_init),
		.divisor  (div_divisor),
		.done     (div_done),
		.rem      (div_rem),
		.quo      (div_quo)
	);

	always_ff @(posedge clk) begin
		if (mul_en) begin
			mul_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
	end

	// work registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_UPD: begin
				fresh_q <= fresh_n;
				lit_q <= lit_n;
				base_r_q <= band_r;
				base_g_q <= band_g;
				idx_q <= '0;
			end
			ST_MODW: begin
				ph_q <= div_rem[15:0];
			end
			ST_IDXW: begin
				idx_q <= div_quo[LOGN-1:0];
			end
			ST_RMUL: begin
				f_q <= f_val;
			end
			ST_GMUL: begin
				red_q <= mul_q[23:16];
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					priority if (!lit_n) begin
						state_q <= ST_FIN;
					end else if (breath_period_ms_q == '0) begin
						state_q <= ST_PMUL;
					end else begin
						state_q <= ST_MODW;
					end
				end
				ST_MODW: begin
					if (div_done) begin
						state_q <= ST_PHN;
					end
				end
				ST_PHN:   state_q <= ST_IDXGO;
				ST_IDXGO: state_q <= ST_IDXW;
				ST_IDXW: begin
					if (div_done) begin
						state_q <= ST_PMUL;
					end
				end
				ST_PMUL: state_q <= ST_SGO;
				ST_SGO:  state_q <= ST_SW;
				ST_SW: begin
					if (div_done) begin
						state_q <= ST_SSQ;
					end
				end
				ST_SSQ:  state_q <= ST_FMUL;
				ST_FMUL: state_q <= ST_RMUL;
				ST_RMUL: state_q <= ST_GMUL;
				ST_GMUL: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			m_tdata_q <= {5'b0, LVL_OFF,
				lit_q ? mul_q[23:16] : LVL_OFF,
				lit_q ? red_q : LVL_OFF,
				fresh_q, motion_mode_q, screen_on_q};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = m_tdata_q;

endmodule

`default_nettype wire

/* tb/motion_wake_display_led_controller_top_tb.sv */
// testbench for the motion wake display and co2 led controller, self-checking against its own predictor
`default_nettype none

module motion_wake_display_led_controller_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mwdl_pkg::*;

	localparam int STEPS = BREATH_STEPS_DEF;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	typedef struct {
		logic [31:0]        now_ms;
		logic               tap;
		logic               accel_valid;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic [1:0]         kind;
		logic [15:0]        co2_ppm;
	} tick_t;

	typedef struct {
		logic       display_on;
		logic       woke_by_motion;
		logic       data_fresh;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} lamp_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [S_TUSER_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [M_TDATA_W-1:0] m_tdata;

	motion_wake_display_led_controller_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// predictor registers
	logic [16:0] motion_limit;
	logic [15:0] wake_ms;
	logic [15:0] stale_limit;
	logic [15:0] breath_ms;
	logic [7:0]  glow_base;
	logic [15:0] warn_level;
	logic [15:0] crit_level;

	// predictor state
	logic               screen_lit;
	logic               motion_wake;
	logic [31:0]        wake_until;
	logic signed [15:0] last_x, last_y, last_z;
	logic               data_seen;
	logic [31:0]        data_stamp;
	logic               co2_seen;
	logic [15:0]        co2_level;

	int unsigned cos_tab[STEPS];

	lamp_t lamp_q[$];
	int errors = 0;
	int send_idle = 0;
	int recv_idle = 0;

	// stimulus generator memory
	logic [31:0]        sim_ms;
	logic signed [15:0] gen_x, gen_y, gen_z;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int unsigned sine_squared(int unsigned u);
		longint unsigned p, den, s;
		p = longint'(u) * longint'(STEPS - u);
		den = 5 * longint'(STEPS) * STEPS - 4 * p;
		s = (16 * p * 65536) / den;
		return int'((s * s + 32768) >> 16);
	endfunction

	function automatic int unsigned abs_step(logic signed [15:0] a, logic signed [15:0] b);
		int d;
		d = int'(a) - int'(b);
		return (d < 0) ? -d : d;
	endfunction

	task automatic reset_model();
		motion_limit = MOTION_THRESHOLD_RST;
		wake_ms = WAKE_DURATION_MS_RST;
		stale_limit = STALE_MS_RST;
		breath_ms = BREATH_PERIOD_MS_RST;
		glow_base = BREATH_FLOOR_RST;
		warn_level = WARN_PPM_RST;
		crit_level = CRIT_PPM_RST;
		screen_lit = 1'b1;
		motion_wake = 1'b0;
		wake_until = '0;
		last_x = '0;
		last_y = '0;
		last_z = '0;
		data_seen = 1'b0;
		data_stamp = '0;
		co2_seen = 1'b0;
		co2_level = '0;
		for (int i = 0; i < STEPS; i++) cos_tab[i] = sine_squared(i);
	endtask

	task automatic predict_lamp(input tick_t t, output lamp_t r);
		int unsigned step_sum;
		logic moved;
		logic [31:0] gap;
		logic fresh;
		longint unsigned idx, f, red, grn;
		step_sum = 0;
		red = 0;
		grn = 0;
		if (t.tap) begin
			screen_lit = !screen_lit;
			motion_wake = 1'b0;
		end
		if (t.accel_valid) begin
			step_sum = abs_step(t.accel_x, last_x) + abs_step(t.accel_y, last_y)
				+ abs_step(t.accel_z, last_z);
			moved = step_sum > motion_limit;
			last_x = t.accel_x;
			last_y = t.accel_y;
			last_z = t.accel_z;
			if (!screen_lit && moved) begin
				screen_lit = 1'b1;
				motion_wake = 1'b1;
				wake_until = t.now_ms + wake_ms;
			end else if (motion_wake && moved) begin
				wake_until = t.now_ms + wake_ms;
			end
		end
		gap = t.now_ms - wake_until;
		if (motion_wake && screen_lit && !gap[31]) begin
			screen_lit = 1'b0;
			motion_wake = 1'b0;
		end
		if (t.kind == KIND_CO2) begin
			co2_level = t.co2_ppm;
			co2_seen = 1'b1;
		end
		if (t.kind == KIND_CO2 || t.kind == KIND_OTHER) begin
			data_stamp = t.now_ms;
			data_seen = 1'b1;
		end
		gap = t.now_ms - data_stamp;
		fresh = data_seen && (gap < 32'(stale_limit));
		if (screen_lit && fresh && co2_seen) begin
			if (co2_level < warn_level) begin
				red = LVL_OFF;
				grn = LVL_FULL;
			end else if (co2_level <= crit_level) begin
				red = LVL_FULL;
				grn = LVL_AMBER_G;
			end else begin
				red = LVL_FULL;
				grn = LVL_OFF;
			end
			idx = 0;
			if (breath_ms != 0) begin
				idx = ((longint'(t.now_ms) % breath_ms) * STEPS) / breath_ms;
				if (idx >= STEPS) idx = STEPS - 1;
			end
			f = longint'(glow_base) * 256
				+ (((256 - longint'(glow_base)) * cos_tab[idx] + 128) >> 8);
			red = (red * f) >> 16;
			grn = (grn * f) >> 16;
		end
		r.display_on = screen_lit;
		r.woke_by_motion = motion_wake;
		r.data_fresh = fresh;
		r.red = red[7:0];
		r.green = grn[7:0];
		r.blue = LVL_OFF;
	endtask

	function automatic tick_t mk(logic [31:0] now, logic tap, logic av, int x, int y, int z,
			logic [1:0] kind, logic [15:0] ppm);
		tick_t t;
		t.now_ms = now;
		t.tap = tap;
		t.accel_valid = av;
		t.accel_x = 16'(x);
		t.accel_y = 16'(y);
		t.accel_z = 16'(z);
		t.kind = kind;
		t.co2_ppm = ppm;
		return t;
	endfunction

	// entered and left just after a falling edge; s_tvalid stays high on return
	task automatic send_tick(input tick_t t);
		lamp_t want;
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		predict_lamp(t, want);
		lamp_q.push_back(want);
		s_tvalid <= 1'b1;
		s_tdata <= {7'b0, t.co2_ppm, t.accel_z, t.accel_y, t.accel_x, t.tap, t.now_ms};
		s_tuser <= {t.kind, t.accel_valid};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (lamp_q.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(value);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_MOTION_THRESHOLD: motion_limit = 17'(value);
			REG_WAKE_DURATION_MS: wake_ms = 16'(value);
			REG_STALE_MS: stale_limit = 16'(value);
			REG_BREATH_PERIOD_MS: breath_ms = 16'(value);
			REG_BREATH_FLOOR: glow_base = 8'(value);
			REG_WARN_PPM: warn_level = 16'(value);
			REG_CRIT_PPM: crit_level = 16'(value);
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_setting(int unsigned thr, int unsigned wake, int unsigned stale,
			int unsigned period, int unsigned fl, int unsigned warn, int unsigned crit);
		drain();
		write_reg(REG_MOTION_THRESHOLD, thr);
		write_reg(REG_WAKE_DURATION_MS, wake);
		write_reg(REG_STALE_MS, stale);
		write_reg(REG_BREATH_PERIOD_MS, period);
		write_reg(REG_BREATH_FLOOR, fl);
		write_reg(REG_WARN_PPM, warn);
		write_reg(REG_CRIT_PPM, crit);
	endtask

	task automatic make_tick(output tick_t t);
		int pick;
		pick = $urandom_range(99);
		if (pick < 85) sim_ms += $urandom_range(0, 1500);
		else if (pick < 95) sim_ms += $urandom_range(0, 70000);
		else sim_ms = $urandom;
		t.now_ms = sim_ms;
		t.tap = ($urandom_range(99) < 4);
		t.accel_valid = ($urandom_range(99) < 50);
		if ($urandom_range(99) < 75) begin
			gen_x += 16'($urandom_range(0, 240)) - 16'sd120;
			gen_y += 16'($urandom_range(0, 240)) - 16'sd120;
			gen_z += 16'($urandom_range(0, 240)) - 16'sd120;
		end else begin
			gen_x = 16'($urandom);
			gen_y = 16'($urandom);
			gen_z = 16'($urandom);
		end
		t.accel_x = gen_x;
		t.accel_y = gen_y;
		t.accel_z = gen_z;
		pick = $urandom_range(99);
		if (pick < 50) t.kind = KIND_NONE;
		else if (pick < 75) t.kind = KIND_CO2;
		else if (pick < 90) t.kind = KIND_OTHER;
		else t.kind = KIND_SPARE;
		pick = $urandom_range(3);
		case (pick)
			0: t.co2_ppm = warn_level + 16'($urandom_range(0, 4)) - 16'd2;
			1: t.co2_ppm = crit_level + 16'($urandom_range(0, 4)) - 16'd2;
			2: t.co2_ppm = 16'($urandom_range(300, 2500));
			default: t.co2_ppm = 16'($urandom);
		endcase
	endtask

	task automatic run_random(int count);
		tick_t t;
		for (int i = 0; i < count; i++) begin
			make_tick(t);
			send_tick(t);
			if ($urandom_range(99) == 0) drain();
		end
	endtask

	task automatic test_directed_defaults();
		send_tick(mk(0, 0, 0, 0, 0, 0, KIND_NONE, 0));
		send_tick(mk(100, 0, 0, 0, 0, 0, KIND_OTHER, 0));
		send_tick(mk(1250, 0, 0, 0, 0, 0, KIND_CO2, 400));
		send_tick(mk(2500, 0, 0, 0, 0, 0, KIND_CO2, 1000));
		send_tick(mk(3000, 0, 0, 0, 0, 0, KIND_CO2, 1500));
		send_tick(mk(3500, 0, 0, 0, 0, 0, KIND_CO2, 1501));
		send_tick(mk(4999, 0, 0, 0, 0, 0, KIND_CO2, 65535));
		send_tick(mk(5000, 0, 0, 0, 0, 0, KIND_CO2, 0));
		// unknown kind leaves the co2 value and data time alone
		send_tick(mk(5100, 0, 0, 0, 0, 0, KIND_SPARE, 16'hffff));
		send_tick(mk(5200, 1, 0, 0, 0, 0, KIND_NONE, 0));
		send_tick(mk(5300, 0, 1, 32767, -32768, 32767, KIND_NONE, 0));
		send_tick(mk(9000, 0, 1, -32768, 32767, -32768, KIND_NONE, 0));
		send_tick(mk(15999, 0, 0, 0, 0, 0, KIND_NONE, 0));
		send_tick(mk(16000, 0, 0, 0, 0, 0, KIND_NONE, 0));
		send_tick(mk(16100, 0, 1, -32768, 32767, -32768, KIND_NONE, 0));
		// a step of exactly the limit does not count, one more does
		send_tick(mk(16200, 0, 1, -32568, 32667, -32710, KIND_NONE, 0));
		send_tick(mk(16300, 0, 1, -32209, 32667, -32710, KIND_NONE, 0));
		send_tick(mk(16400, 1, 0, 0, 0, 0, KIND_NONE, 0));
		send_tick(mk(16450, 1, 1, 32767, 32767, 32767, KIND_NONE, 0));
		send_tick(mk(34999, 0, 0, 0, 0, 0, KIND_NONE, 0));
		send_tick(mk(35000, 0, 0, 0, 0, 0, KIND_NONE, 0));
		// timestamp wrap
		send_tick(mk(32'hffff_fff0, 0, 0, 0, 0, 0, KIND_CO2, 1200));
		send_tick(mk(32'h0000_0010, 1, 0, 0, 0, 0, KIND_NONE, 0));
		send_tick(mk(32'hffff_ffff, 1, 1, 0, 0, 0, KIND_OTHER, 16'hffff));
	endtask

	task automatic test_register_extremes();
		apply_setting(0, 0, 0, 0, 0, 0, 0);
		run_random(25);
		apply_setting(131071, 65535, 65535, 65535, 255, 65535, 65535);
		run_random(25);
		// crossed co2 limits
		apply_setting(1, 1, 1, 1, 128, 2000, 500);
		run_random(25);
		apply_setting(358, 7000, 30000, 3, 13, 1000, 1500);
		run_random(25);
		apply_setting(200, 3000, 20000, 1, 0, 800, 1200);
		run_random(25);
		apply_setting(20, 65535, 65535, 256, 255, 0, 65535);
		run_random(25);
	endtask

	task automatic test_random_traffic(int s_idle, int r_idle, int count);
		send_idle = s_idle;
		recv_idle = r_idle;
		apply_setting($urandom_range(0, 1500), $urandom_range(0, 12000),
			$urandom_range(1, 65535), $urandom_range(1, 8000), $urandom_range(0, 255),
			$urandom_range(400, 1500), $urandom_range(900, 2500));
		run_random(count);
	endtask

	always @(negedge clk) begin
		if (!arst_n) m_tready <= 1'b0;
		else m_tready <= ($urandom_range(99) >= recv_idle);
	end

	function automatic int field_bad(string name, int unsigned want, int unsigned got);
		if (want == got) return 0;
		$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk) begin : check_lamp
		lamp_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (lamp_q.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual %h", $time, m_tdata);
				errors++;
			end else begin
				want = lamp_q.pop_front();
				errors += field_bad("display_on", want.display_on, m_tdata[0]);
				errors += field_bad("woke_by_motion", want.woke_by_motion, m_tdata[1]);
				errors += field_bad("data_fresh", want.data_fresh, m_tdata[2]);
				errors += field_bad("led_red", want.red, m_tdata[10:3]);
				errors += field_bad("led_green", want.green, m_tdata[18:11]);
				errors += field_bad("led_blue", want.blue, m_tdata[26:19]);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		sim_ms = 32'd40000;
		gen_x = '0;
		gen_y = '0;
		gen_z = '0;
		reset_model();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle = 9;
		recv_idle = 81;
		test_directed_defaults();
		test_register_extremes();
		test_random_traffic(9, 81, 290);
		test_random_traffic(81, 9, 290);
		test_random_traffic(0, 0, 290);

		drain();
		repeat (80) @(negedge clk);
		if (errors == 0 && lamp_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire
